// File: rtl/core/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants for the tiny execute core.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int unsigned PcW     = 6;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned NumRegs = 16;
  localparam int unsigned InstrW  = 16;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 24;

  typedef enum logic {
    FuncLoad = 1'b0,
    FuncStep = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    OpLdi = 3'd0,
    OpAdd = 3'd1,
    OpAnd = 3'd2,
    OpOr  = 3'd3,
    OpXor = 3'd4,
    OpPrt = 3'd5,
    OpRdd = 3'd6,
    OpBlt = 3'd7
  } op_e;

  typedef struct packed {
    logic                 branch_fault;
    logic                 stopped;
    logic                 read_taken;
    logic [ByteW-1:0]     print_value;
    logic [RegIdxW-1:0]   print_register;
    logic                 print_valid;
    logic [PcW-1:0]       pc_after;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

// File: rtl/core/tiny_cpu_execute_core.sv
// ----------------------------------------------------------------------------
// tiny_cpu_execute_core
// 8-bit core with 16-bit instructions, 16 registers and a byte program memory.
// ----------------------------------------------------------------------------
// One word in, one word out, one word per cycle sustained while not stalled.
// Each accepted word sits in an input stage that already holds its fetched
// instruction and both register operands, then its result is registered at
// the output; the rate is set by the path from the held instruction's
// compare through the next-pc select, the program fetch and the register
// file read. tuser = 0 loads a program byte (and restarts at pc 0),
// tuser = 1 executes one instruction. Write program_length only while idle.
module tiny_cpu_execute_core
  import tce_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config: program_length
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PcW-1:0]      cfg_data_i,
  // in: [4:0] load_address, [12:5] load_byte, [20:13] read_value
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // in: [0] func
  input  logic                s_axis_tuser,
  // out: [5:0] pc_after, [6] print_valid, [10:7] print_register,
  //      [18:11] print_value, [19] read_taken, [20] stopped, [21] branch_fault
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned Rows = (MEM_BYTES + 1) / 2;
  localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam logic [AddrW-1:0] RowCnt = AddrW'(Rows);
  localparam logic [PcW-1:0]   MemLim = PcW'(MEM_BYTES);

  // architectural state
  logic [InstrW-1:0]  prog_q [Rows];
  logic [ByteW-1:0]   rf_mem [NumRegs];
  logic [NumRegs-1:0] rf_vld_q;
  logic [PcW-1:0]     pc_q;
  logic               halted_q;
  logic [PcW-1:0]     len_q;

  // input stage
  logic               s1_vld_q;
  func_e              s1_func_q;
  logic [AddrW-1:0]   s1_laddr_q;
  logic [ByteW-1:0]   s1_lbyte_q;
  logic [ByteW-1:0]   s1_rval_q;
  logic [InstrW-1:0]  s1_word_q;
  logic [PcW-1:0]     s1_pc_q;
  logic               s1_halt_q;
  logic [ByteW-1:0]   s1_a_q;
  logic [ByteW-1:0]   s1_b_q;

  // output stage
  logic               out_vld_q;
  result_t            out_q;

  logic s1_adv, acc;

  assign cfg_ready_o   = 1'b1;
  assign s1_adv        = s1_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // ---- execute the held word ----
  op_e                ex_op;
  logic [RegIdxW-1:0] ex_ia, ex_ic;
  result_t            ex_res;
  logic [PcW-1:0]     ex_pc;
  logic               ex_halt;
  logic               ex_rf_we;
  logic [RegIdxW-1:0] ex_rf_wa;
  logic [ByteW-1:0]   ex_rf_wd;
  logic               ex_pm_we;
  logic [PcW-1:0]     pc_inc;
  logic [4:0]         target;

  assign ex_op  = op_e'(s1_word_q[15:13]);
  assign ex_ia  = s1_word_q[12:9];
  assign ex_ic  = s1_word_q[4:1];
  assign target = s1_word_q[4:0];
  assign pc_inc = s1_pc_q + PcW'(2);

  always_comb begin
    ex_res   = '0;
    ex_pc    = s1_pc_q;
    ex_halt  = s1_halt_q;
    ex_rf_we = 1'b0;
    ex_rf_wa = ex_ia;
    ex_rf_wd = '0;
    ex_pm_we = 1'b0;
    if (s1_func_q == FuncLoad) begin
      ex_pm_we = ({1'b0, s1_laddr_q} < MemLim);
      ex_pc    = '0;
      ex_halt  = 1'b0;
    end else if (!s1_halt_q) begin
      ex_pc = pc_inc;
      unique case (ex_op)
        OpLdi: begin
          ex_rf_we = 1'b1;
          ex_rf_wd = s1_word_q[8:1];
        end
        OpAdd: begin
          ex_rf_we = 1'b1;
          ex_rf_wa = ex_ic;
          ex_rf_wd = s1_a_q + s1_b_q;
        end
        OpAnd: begin
          ex_rf_we = 1'b1;
          ex_rf_wa = ex_ic;
          ex_rf_wd = s1_a_q & s1_b_q;
        end
        OpOr: begin
          ex_rf_we = 1'b1;
          ex_rf_wa = ex_ic;
          ex_rf_wd = s1_a_q | s1_b_q;
        end
        OpXor: begin
          ex_rf_we = 1'b1;
          ex_rf_wa = ex_ic;
          ex_rf_wd = s1_a_q ^ s1_b_q;
        end
        OpPrt: begin
          ex_res.print_valid    = 1'b1;
          ex_res.print_register = ex_ia;
          ex_res.print_value    = s1_a_q;
        end
        OpRdd: begin
          ex_rf_we          = 1'b1;
          ex_rf_wd          = s1_rval_q;
          ex_res.read_taken = 1'b1;
        end
        OpBlt: begin
          if (s1_a_q < s1_b_q) begin
            if (target[0]) begin
              ex_res.branch_fault = 1'b1;
              ex_halt             = 1'b1;
            end else begin
              ex_pc = {1'b0, target};
            end
          end
        end
        default: ;
      endcase
      if (ex_pc >= len_q || ex_pc >= MemLim) begin
        ex_halt = 1'b1;
      end
    end
    ex_res.pc_after = ex_pc;
    ex_res.stopped  = ex_halt;
  end

  // ---- fetch for the next word, seeing the held word's effects ----
  logic [PcW-1:0]     nx_pc;
  logic               nx_halt;
  logic [AddrW-1:0]   fetch_row;
  logic [InstrW-1:0]  fetch_word;
  logic [RowW-1:0]    ld_row;
  logic [RegIdxW-1:0] rd_a, rd_b;
  logic               rf_we;

  assign nx_pc     = s1_vld_q ? ex_pc : pc_q;
  assign nx_halt   = s1_vld_q ? ex_halt : halted_q;
  assign fetch_row = nx_pc[PcW-1:1];
  assign ld_row    = s1_laddr_q[RowW:1];

  always_comb begin
    fetch_word = '0;
    if (fetch_row < RowCnt) begin
      fetch_word = prog_q[fetch_row[RowW-1:0]];
      if (s1_vld_q && ex_pm_we && ld_row == fetch_row[RowW-1:0]) begin
        if (s1_laddr_q[0]) begin
          fetch_word[7:0] = s1_lbyte_q;
        end else begin
          fetch_word[15:8] = s1_lbyte_q;
        end
      end
    end
  end

  assign rd_a  = fetch_word[12:9];
  assign rd_b  = fetch_word[8:5];
  assign rf_we = s1_adv && ex_rf_we;

  // ---- control and architectural state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q      <= '0;
      halted_q  <= 1'b0;
      len_q     <= '0;
      rf_vld_q  <= '0;
      for (int i = 0; i < Rows; i++) begin
        prog_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
      s1_vld_q  <= acc || (s1_vld_q && !s1_adv);
      out_vld_q <= s1_adv || (out_vld_q && !m_axis_tready);
      if (s1_adv) begin
        pc_q     <= ex_pc;
        halted_q <= ex_halt;
        if (ex_pm_we) begin
          if (s1_laddr_q[0]) begin
            prog_q[ld_row][7:0] <= s1_lbyte_q;
          end else begin
            prog_q[ld_row][15:8] <= s1_lbyte_q;
          end
        end
      end
      if (rf_we) begin
        rf_vld_q[ex_rf_wa] <= 1'b1;
      end
    end
  end

  // register file: one write, two registered reads (write-first)
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[ex_rf_wa] <= ex_rf_wd;
    end
    if (acc) begin
      if (rf_we && ex_rf_wa == rd_a) begin
        s1_a_q <= ex_rf_wd;
      end else begin
        s1_a_q <= rf_vld_q[rd_a] ? rf_mem[rd_a] : '0;
      end
      if (rf_we && ex_rf_wa == rd_b) begin
        s1_b_q <= ex_rf_wd;
      end else begin
        s1_b_q <= rf_vld_q[rd_b] ? rf_mem[rd_b] : '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_func_q  <= func_e'(s_axis_tuser);
      s1_laddr_q <= s_axis_tdata[4:0];
      s1_lbyte_q <= s_axis_tdata[12:5];
      s1_rval_q  <= s_axis_tdata[20:13];
      s1_word_q  <= fetch_word;
      s1_pc_q    <= nx_pc;
      s1_halt_q  <= nx_halt;
    end
    if (s1_adv) begin
      out_q <= ex_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - ResultW)'(0), out_q};

endmodule

// File: rtl/core/tce_checker.sv
// ----------------------------------------------------------------------------
// tce_checker
// Port-level checks for the tiny execute core, bound to the top level.
// ----------------------------------------------------------------------------
module tce_checker
  import tce_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // result word held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // pc only ever moves by two or to an even target
  a_pc_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[0])
    else $error("odd pc reported");

  // a faulting branch always halts the core
  a_fault_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[20])
    else $error("branch fault without stop");

  // print, read and fault come from different opcodes
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones({m_axis_tdata[6], m_axis_tdata[19], m_axis_tdata[21]}) <= 1)
    else $error("more than one event flag in a word");

endmodule

bind tiny_cpu_execute_core tce_checker u_tce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tiny execute core: loads programs, steps them
// with random read values and length settings, and compares every result word
// with a cycle-free predictor of the core, under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import tce_pkg::*;

  localparam int unsigned MemBytes      = 32;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned TimeoutCycles = 200000;

  typedef struct {
    func_e             func;
    logic [AddrW-1:0]  load_address;
    logic [ByteW-1:0]  load_byte;
    logic [ByteW-1:0]  read_value;
  } core_item_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [PcW-1:0]      cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [4:0] load_address, [12:5] load_byte, [20:13] read_value
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // [0] func
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [5:0] pc_after, [6] print_valid, [10:7] print_register, [18:11] print_value,
  // [19] read_taken, [20] stopped, [21] branch_fault
  logic [OutDataW-1:0] m_axis_tdata;

  core_item_t    word_q[$];
  result_t       expected_q[$];
  logic [15:0]   prog_words[$];
  core_item_t    cur;

  // predictor state
  logic [ByteW-1:0] prog_mem [MemBytes];
  logic [ByteW-1:0] cpu_regs [NumRegs];
  logic [PcW-1:0]   cpu_pc     = '0;
  logic             cpu_halted = 1'b0;
  logic [PcW-1:0]   prog_len   = '0;

  bit          word_taken    = 1'b0;
  bit          idle_on       = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned tx_gap        = 0;
  int unsigned rx_hold       = 0;
  int unsigned n_queued      = 0;
  int unsigned n_accepted    = 0;
  int unsigned n_results     = 0;
  int unsigned n_prints      = 0;
  int unsigned n_reads       = 0;
  int unsigned n_faults      = 0;
  int unsigned n_cfg         = 0;
  int unsigned n_errors      = 0;

  tiny_cpu_execute_core #(
    .MEM_BYTES(MemBytes)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < MemBytes; i++) prog_mem[i] = '0;
    for (int i = 0; i < NumRegs; i++) cpu_regs[i] = '0;
  end

  function automatic logic [ByteW-1:0] mem_byte(int unsigned addr);
    return (addr < MemBytes) ? prog_mem[addr] : '0;
  endfunction

  // Executes one word against the predictor state and returns its result.
  function automatic result_t exec_word(core_item_t it);
    result_t          r;
    logic [15:0]      w;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    r = '0;
    if (it.func == FuncLoad) begin
      if (it.load_address < MemBytes) prog_mem[it.load_address] = it.load_byte;
      cpu_pc     = '0;
      cpu_halted = 1'b0;
    end else if (!cpu_halted) begin
      w = {mem_byte(cpu_pc), mem_byte(cpu_pc + 1)};
      a = cpu_regs[w[12:9]];
      b = cpu_regs[w[8:5]];
      cpu_pc = cpu_pc + 6'd2;
      case (op_e'(w[15:13]))
        OpLdi: cpu_regs[w[12:9]] = w[8:1];
        OpAdd: cpu_regs[w[4:1]] = a + b;
        OpAnd: cpu_regs[w[4:1]] = a & b;
        OpOr:  cpu_regs[w[4:1]] = a | b;
        OpXor: cpu_regs[w[4:1]] = a ^ b;
        OpPrt: begin
          r.print_valid    = 1'b1;
          r.print_register = w[12:9];
          r.print_value    = a;
        end
        OpRdd: begin
          cpu_regs[w[12:9]] = it.read_value;
          r.read_taken      = 1'b1;
        end
        OpBlt: begin
          if (a < b) begin
            if (w[0]) begin
              r.branch_fault = 1'b1;
              cpu_halted     = 1'b1;
            end else begin
              cpu_pc = {1'b0, w[4:0]};
            end
          end
        end
        default: ;
      endcase
      if (cpu_pc >= prog_len || cpu_pc >= MemBytes) cpu_halted = 1'b1;
    end
    r.pc_after = cpu_pc;
    r.stopped  = cpu_halted;
    return r;
  endfunction

  function automatic logic [15:0] instr(op_e op, logic [3:0] ra, logic [3:0] rb,
                                        logic [4:0] tail);
    return {op, ra, rb, tail};
  endfunction

  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    w = 16'($urandom_range(0, 16'hFFFF));
    // mostly even branch targets so taken branches keep running
    if (op_e'(w[15:13]) == OpBlt && $urandom_range(0, 4) != 0) w[0] = 1'b0;
    return w;
  endfunction

  task automatic push_load(logic [AddrW-1:0] addr, logic [ByteW-1:0] val);
    core_item_t it;
    it.func         = FuncLoad;
    it.load_address = addr;
    it.load_byte    = val;
    it.read_value   = ByteW'($urandom_range(0, 255));
    word_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_step(logic [ByteW-1:0] rv);
    core_item_t it;
    it.func         = FuncStep;
    it.load_address = AddrW'($urandom_range(0, 31));
    it.load_byte    = ByteW'($urandom_range(0, 255));
    it.read_value   = rv;
    word_q.push_back(it);
    n_queued++;
  endtask

  // big-endian: high byte at the even address
  task automatic load_program(int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++) begin
      push_load(AddrW'(i), i[0] ? prog_words[i / 2][7:0] : prog_words[i / 2][15:8]);
    end
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_len(logic [PcW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    prog_len = v;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random programs, each followed by a run of steps; a few stray loads and
  // partly loaded programs mixed in.
  task automatic run_programs(int unsigned budget);
    int unsigned first;
    int unsigned nw;
    int unsigned nbytes;
    int unsigned nsteps;
    first = n_queued;
    while (n_queued - first < budget) begin
      nw = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(2, 6);
      prog_words.delete();
      for (int unsigned i = 0; i < nw; i++) prog_words.push_back(rand_instr());
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2 * nw) : 2 * nw;
      load_program(nbytes);
      nsteps = $urandom_range(1, nw + 4);
      for (int unsigned s = 0; s < nsteps; s++) begin
        if ($urandom_range(0, 19) == 0)
          push_load(AddrW'($urandom_range(0, 31)), ByteW'($urandom_range(0, 255)));
        else
          push_step(ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  // input side: accept at the rising edge, drive at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      word_taken = 1'b1;
      expected_q.push_back(exec_word(cur));
      n_accepted++;
    end
  end

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || word_taken) begin
      word_taken = 1'b0;
      if (tx_gap != 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (word_q.size() != 0) begin
        cur = word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cur.read_value, cur.load_byte, cur.load_address};
        s_axis_tuser  <= cur.func;
        if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (long_hold_req) begin
      rx_hold       = LongHold;
      long_hold_req = 1'b0;
    end else if (rx_hold == 0 && idle_on && $urandom_range(0, 7) == 0) begin
      rx_hold = $urandom_range(1, 10);
    end
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // output side
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[ResultW-1:0]);
      if (expected_q.size() == 0) begin
        $error("result word with no expected value: %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("pc_after", want.pc_after, got.pc_after);
        check_field("print_valid", want.print_valid, got.print_valid);
        check_field("print_register", want.print_register, got.print_register);
        check_field("print_value", want.print_value, got.print_value);
        check_field("read_taken", want.read_taken, got.read_taken);
        check_field("stopped", want.stopped, got.stopped);
        check_field("branch_fault", want.branch_fault, got.branch_fault);
        n_results++;
        n_prints += want.print_valid;
        n_reads  += want.read_taken;
        n_faults += want.branch_fault;
      end
    end
  end

  initial begin
    #(TimeoutCycles * 20);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [PcW-1:0] lens [5];
    lens = '{6'd63, 6'd0, 6'd12, 6'd32, 6'($urandom_range(2, 31))};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // step straight out of reset with length 0: executes once, then stops
    push_step(8'h00);
    wait_idle();

    write_len(6'd32);
    prog_words = '{
      instr(OpLdi, 4'd1, 4'hF, 5'h1E),         // r1 = 0xFF
      instr(OpRdd, 4'd15, 4'd0, 5'd0),         // r15 = read value
      instr(OpAdd, 4'd1, 4'd15, {4'd2, 1'b0}), // wraps
      instr(OpAnd, 4'd1, 4'd15, {4'd3, 1'b1}),
      instr(OpOr,  4'd2, 4'd3, {4'd4, 1'b0}),
      instr(OpXor, 4'd15, 4'd1, {4'd5, 1'b0}),
      instr(OpPrt, 4'd2, 4'd0, 5'd0),
      instr(OpBlt, 4'd15, 4'd1, 5'd3)          // taken, odd target: fault
    };
    load_program(16);
    repeat (9) push_step(8'hA5);                // last one lands while stopped
    wait_idle();

    for (int k = 0; k < 5; k++) begin
      write_len(lens[k]);
      if (k == 1) long_hold_req = 1'b1;
      if (k == 2) begin
        run_programs(28);
        wait_idle();
        run_programs(28);
      end else begin
        run_programs(55);
      end
      wait_idle();
    end

    idle_on = 1'b0;
    write_len(6'd20);
    run_programs(45);
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d words through the core over %0d length settings;", n_accepted, n_cfg);
    $display("checked %0d results: %0d prints, %0d reads, %0d branch faults.",
             n_results, n_prints, n_reads, n_faults);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
